// ===== rtl/rta_pkg.sv =====
// ----------------------------------------------------------------------------
// Route table aging package
// Shared types, constants and codes for the route table with aging.
// ----------------------------------------------------------------------------
package rta_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [31:0] AGE_LIMIT_RST = 32'd60;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_SEARCH_IP = 2'd1;
    localparam logic [1:0] FUNC_SEARCH_EXACT = 2'd2;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    localparam logic [2:0] ST_HIT = 3'd0;
    localparam logic [2:0] ST_MISS = 3'd1;
    localparam logic [2:0] ST_NEW = 3'd2;
    localparam logic [2:0] ST_UPDATED = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    localparam logic [0:0] REG_AGE_LIMIT = 1'b0;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] dest_addr;
        logic [47:0] next_hop_mac;
        logic [31:0] brd_id;
        logic [7:0]  iface_index;
        logic [7:0]  hop_cnt;
        logic [31:0] now_seconds;
    } rta_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] out_mac;
        logic [7:0]  out_iface;
        logic [7:0]  out_hops;
        logic [31:0] out_brd_id;
    } rta_out_t;

    // One table entry as it travels around the ring of cells.
    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [31:0] bcast;
        logic [47:0] mac;
        logic [7:0]  iface;
        logic [7:0]  hops;
        logic [31:0] stamp;
    } rta_entry_t;

    // Command from the sequencer to the ring; shift goes to every cell.
    typedef struct packed {
        logic shift;  // rotate the ring by one place
        logic purge;  // drop the entry leaving the head if it has aged out
        logic write;  // replace the entry leaving the head with wr_entry
    } rta_ctrl_t;

endpackage

// ===== rtl/rta_cell.sv =====
// ----------------------------------------------------------------------------
// Route table cell
// Holds one table entry and passes it to its neighbor on every shift.
// ----------------------------------------------------------------------------
module rta_cell
    import rta_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift,
    input  rta_entry_t d_in,
    output rta_entry_t q_out
);

    rta_entry_t entry_reg;

    // Only the valid bit is reset; the payload means nothing while it is low.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else if (shift) begin
            entry_reg <= d_in;
        end
    end

    assign q_out = entry_reg;

endmodule

// ===== rtl/rta_ring.sv =====
// ----------------------------------------------------------------------------
// Route table ring
// A rotating chain of cells. The head entry may be purged or rewritten as it
// wraps back to the tail, so one rotation visits every entry in index order.
// ----------------------------------------------------------------------------
module rta_ring
    import rta_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  rta_ctrl_t  ctrl,
    input  rta_entry_t wr_entry,
    output rta_entry_t head
);

    rta_entry_t link [TABLE_ENTRIES+1];
    rta_entry_t back;

    assign head = link[0];

    always_comb begin
        back = link[0];
        if (ctrl.write) begin
            back = wr_entry;
        end else if (ctrl.purge) begin
            back.valid = 1'b0;
        end
    end

    assign link[TABLE_ENTRIES] = back;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        rta_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (ctrl.shift),
            .d_in    (link[g+1]),
            .q_out   (link[g])
        );
    end

endmodule

// ===== rtl/route_table_aging_core.sv =====
// ----------------------------------------------------------------------------
// Route table aging core
// Route table with aging, held in a rotating chain of entry cells.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_data (rta_in_t)
// m_        out        m_valid, m_ready, m_data (rta_out_t)
// APB       in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// An insert takes three laps of the cell chain: one purges, one finds the
// match or the first free slot, one writes. A search hit takes a scan lap
// and a write lap that refreshes the stamp, a search miss the scan lap only,
// and an unused function code goes straight to the reply. Items are handled
// one at a time; s_ready rises the cycle after the result is taken. Reset
// clears all valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module route_table_aging_core
    import rta_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  rta_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rta_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        IDLE,
        PURGE,
        SCAN,
        REPLY,
        HOLD
    } state_t;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    rta_in_t         item_reg;
    logic [31:0]     timeout_reg;
    logic            found_reg, found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic            free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic            m_valid_reg, m_valid_next;
    rta_out_t        out_reg, out_next;

    rta_ctrl_t  ctrl;
    rta_entry_t head, wr_entry;
    logic       match, aged;
    logic [IDX_W-1:0] pos;
    logic [31:0] age;

    assign pready = 1'b1;
    assign prdata = timeout_reg;
    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= AGE_LIMIT_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_AGE_LIMIT) begin
            timeout_reg <= pwdata;
        end
    end

    rta_ring u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .wr_entry (wr_entry),
        .head     (head)
    );

    assign pos = cnt_reg[IDX_W-1:0];
    assign age = item_reg.now_seconds - head.stamp;
    assign aged = head.valid && (age > timeout_reg);
    assign match = head.valid && head.ip == item_reg.dest_addr &&
                   (item_reg.func == FUNC_SEARCH_IP || head.bcast == item_reg.brd_id);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        m_valid_next  = m_valid_reg;
        out_next      = out_reg;
        ctrl          = '0;
        wr_entry      = head;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    if (s_data.func == FUNC_INSERT) begin
                        state_next = PURGE;
                    end else if (s_data.func == FUNC_SEARCH_IP ||
                                 s_data.func == FUNC_SEARCH_EXACT) begin
                        state_next = SCAN;
                    end else begin
                        state_next = REPLY;
                    end
                end
            end
            PURGE: begin
                ctrl.shift = 1'b1;
                ctrl.purge = aged;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TABLE_ENTRIES - 1)) begin
                    cnt_next   = '0;
                    state_next = SCAN;
                end
            end
            SCAN: begin
                // Record the lowest-index match and the lowest free slot, which only an
                // insert uses. The chosen entry is written on the following lap
                // in HOLD, once it is known whether any match exists.
                ctrl.shift = 1'b1;
                if (!found_reg && match) begin
                    found_next   = 1'b1;
                    hit_idx_next = pos;
                end
                if (!free_reg && !head.valid) begin
                    free_next     = 1'b1;
                    free_idx_next = pos;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TABLE_ENTRIES - 1)) begin
                    cnt_next   = '0;
                    state_next = (item_reg.func == FUNC_INSERT) ? HOLD : REPLY;
                    if (item_reg.func != FUNC_INSERT && !(found_next)) begin
                        state_next = REPLY;
                    end else if (item_reg.func != FUNC_INSERT) begin
                        state_next = HOLD;
                    end
                end
            end
            HOLD: begin
                // Write lap: rewrite the chosen entry as it leaves the head.
                ctrl.shift = 1'b1;
                if (found_reg && pos == hit_idx_reg) begin
                    ctrl.write     = 1'b1;
                    wr_entry.stamp = item_reg.now_seconds;
                    if (item_reg.func == FUNC_INSERT &&
                        item_reg.hop_cnt < head.hops) begin
                        wr_entry.mac   = item_reg.next_hop_mac;
                        wr_entry.iface = item_reg.iface_index;
                        wr_entry.hops  = item_reg.hop_cnt;
                    end
                    out_next.status     = (item_reg.func == FUNC_INSERT) ?
                                          ST_UPDATED : ST_HIT;
                    out_next.out_mac    = wr_entry.mac;
                    out_next.out_iface  = wr_entry.iface;
                    out_next.out_hops   = wr_entry.hops;
                    out_next.out_brd_id = wr_entry.bcast;
                end else if (!found_reg && free_reg && pos == free_idx_reg) begin
                    ctrl.write     = 1'b1;
                    wr_entry.valid = 1'b1;
                    wr_entry.ip    = item_reg.dest_addr;
                    wr_entry.bcast = item_reg.brd_id;
                    wr_entry.mac   = item_reg.next_hop_mac;
                    wr_entry.iface = item_reg.iface_index;
                    wr_entry.hops  = item_reg.hop_cnt;
                    wr_entry.stamp = item_reg.now_seconds;
                    out_next.status     = ST_NEW;
                    out_next.out_mac    = item_reg.next_hop_mac;
                    out_next.out_iface  = item_reg.iface_index;
                    out_next.out_hops   = item_reg.hop_cnt;
                    out_next.out_brd_id = item_reg.brd_id;
                end else if (!found_reg && !free_reg) begin
                    out_next = '0;
                    out_next.status = ST_FULL;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TABLE_ENTRIES - 1)) begin
                    cnt_next     = '0;
                    m_valid_next = 1'b1;
                    state_next   = REPLY;
                end
            end
            REPLY: begin
                if (!m_valid_reg) begin
                    // Miss path and an unused function code arrive here without a result yet.
                    out_next        = '0;
                    out_next.status = ST_MISS;
                    m_valid_next    = 1'b1;
                end else if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            cnt_reg      <= cnt_next;
            found_reg    <= found_next;
            hit_idx_reg  <= hit_idx_next;
            free_reg     <= free_next;
            free_idx_reg <= free_idx_next;
            out_reg      <= out_next;
            if (state_reg == IDLE && s_valid) begin
                item_reg <= s_data;
            end
        end
    end

endmodule

// ===== rtl/rta_checker.sv =====
// ----------------------------------------------------------------------------
// Route table aging checker
// Port-level checks on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module rta_checker
    import rta_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input rta_out_t m_data,
    input logic     pready
);

    // The output holds until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No new transaction is taken while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while result pending");

    // A transaction never completes in the cycle after acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result too early");

    // Status codes stay in range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ST_FULL)
        else $error("bad status");

    assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind route_table_aging_core rta_checker u_rta_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

// ===== tb/sv/route_table_aging_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route table aging core testbench
// Drives inserts and searches through the valid/ready input channel, keeps a
// behavioral copy of the route table with aging, and checks every result
// field by field. The purge timeout is swept over several values through the
// APB port, and the result channel is stalled at random and for long stretches.
// ----------------------------------------------------------------------------
module route_table_aging_core_test;
    import rta_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 2 * TABLE_ENTRIES + 8;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int LONG_HOLD = 400;
    localparam int IN_W = $bits(rta_in_t);

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    rta_in_t     s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    rta_out_t    m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    route_table_aging_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Behavioral copy of the table.
    logic        tbl_valid [TABLE_ENTRIES];
    logic [31:0] tbl_ip    [TABLE_ENTRIES];
    logic [31:0] tbl_bcast [TABLE_ENTRIES];
    logic [47:0] tbl_mac   [TABLE_ENTRIES];
    logic [7:0]  tbl_iface [TABLE_ENTRIES];
    logic [7:0]  tbl_hops  [TABLE_ENTRIES];
    logic [31:0] tbl_stamp [TABLE_ENTRIES];
    logic [31:0] age_limit;

    rta_out_t    pending_routes[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          offering;
    int          burst_left;
    int          hold_req_count;
    int          hold_seen = 0;
    int          hold_cycles = 0;
    bit          stall_mode = 1'b0;
    int          stall_left = 0;
    logic [31:0] clock_now;
    logic [31:0] ip_pool [6];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("route_table_aging_core test failed");
            $finish;
        end
    end

    // Receiver: random stall pattern, plus long hold-offs requested by a test.
    always @(posedge aclk) begin
        if (hold_req_count != hold_seen) begin
            hold_seen <= hold_req_count;
            hold_cycles <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= ($urandom_range(0, 2) != 0);
                stall_left <= $urandom_range(20, 200);
            end else begin
                stall_left <= stall_left - 1;
            end
            m_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    function automatic rta_out_t lookup_route(int i, logic [2:0] status);
        rta_out_t r;
        r.status = status;
        r.out_mac = tbl_mac[i];
        r.out_iface = tbl_iface[i];
        r.out_hops = tbl_hops[i];
        r.out_brd_id = tbl_bcast[i];
        return r;
    endfunction

    function automatic int find_route(logic [31:0] ip, bit use_id, logic [31:0] id);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_ip[i] == ip && (!use_id || tbl_bcast[i] == id))
                return i;
        end
        return -1;
    endfunction

    function automatic rta_out_t predict_route(rta_in_t c);
        rta_out_t    r;
        logic [31:0] age;
        int          hit;
        r = '0;
        r.status = ST_MISS;
        if (c.func == FUNC_INSERT) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                age = c.now_seconds - tbl_stamp[i];
                if (tbl_valid[i] && age > age_limit)
                    tbl_valid[i] = 1'b0;
            end
            hit = find_route(c.dest_addr, 1'b1, c.brd_id);
            if (hit >= 0) begin
                tbl_stamp[hit] = c.now_seconds;
                if (c.hop_cnt < tbl_hops[hit]) begin
                    tbl_mac[hit] = c.next_hop_mac;
                    tbl_iface[hit] = c.iface_index;
                    tbl_hops[hit] = c.hop_cnt;
                end
                return lookup_route(hit, ST_UPDATED);
            end
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!tbl_valid[i]) begin
                    tbl_valid[i] = 1'b1;
                    tbl_ip[i] = c.dest_addr;
                    tbl_bcast[i] = c.brd_id;
                    tbl_mac[i] = c.next_hop_mac;
                    tbl_iface[i] = c.iface_index;
                    tbl_hops[i] = c.hop_cnt;
                    tbl_stamp[i] = c.now_seconds;
                    return lookup_route(i, ST_NEW);
                end
            end
            r.status = ST_FULL;
        end else if (c.func == FUNC_SEARCH_IP || c.func == FUNC_SEARCH_EXACT) begin
            hit = find_route(c.dest_addr, c.func == FUNC_SEARCH_EXACT, c.brd_id);
            if (hit >= 0) begin
                tbl_stamp[hit] = c.now_seconds;
                return lookup_route(hit, ST_HIT);
            end
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge the item was taken or after an idle gap.
    task automatic send_route_cmd(rta_in_t c);
        s_data <= c;
        s_valid <= 1'b1;
        offering = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_routes.push_back(predict_route(c));
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
            burst_left--;
        end
    endtask

    always @(posedge aclk) begin
        rta_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_routes.size() == 0) begin
                $error("unexpected result, status %0d", m_data.status);
                error_count++;
            end else begin
                want = pending_routes.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    error_count++;
                end
                if (m_data.out_mac !== want.out_mac) begin
                    $error("out_mac: expected %h, got %h", want.out_mac, m_data.out_mac);
                    error_count++;
                end
                if (m_data.out_iface !== want.out_iface) begin
                    $error("out_iface: expected %0d, got %0d", want.out_iface,
                           m_data.out_iface);
                    error_count++;
                end
                if (m_data.out_hops !== want.out_hops) begin
                    $error("out_hops: expected %0d, got %0d", want.out_hops, m_data.out_hops);
                    error_count++;
                end
                if (m_data.out_brd_id !== want.out_brd_id) begin
                    $error("out_brd_id: expected %h, got %h", want.out_brd_id,
                           m_data.out_brd_id);
                    error_count++;
                end
            end
        end
    end

    // Lower valid, wait for every result, then give the block time to settle.
    task automatic drain_results();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge aclk); while (pending_routes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_age_limit(logic [31:0] value);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_AGE_LIMIT, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        age_limit = value;
        @(posedge aclk);
    endtask

    function automatic rta_in_t make_cmd(logic [1:0] func, logic [31:0] ip,
                                         logic [31:0] id, logic [7:0] hops,
                                         logic [31:0] now);
        rta_in_t c;
        c.func = func;
        c.dest_addr = ip;
        c.next_hop_mac = 48'({$urandom, $urandom});
        c.brd_id = id;
        c.iface_index = 8'($urandom_range(0, 255));
        c.hop_cnt = hops;
        c.now_seconds = now;
        return c;
    endfunction

    // Mostly inserts and searches over a small set of addresses with a slowly
    // moving clock, so entries match, refresh, fill the table and age out.
    function automatic rta_in_t random_cmd();
        rta_in_t c;
        int      roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            c = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            return c;
        end
        if (roll < 12)
            clock_now = $urandom;
        else
            clock_now = clock_now + $urandom_range(0, 4);
        c = make_cmd($urandom_range(0, 99) < 50 ? FUNC_INSERT :
                     ($urandom_range(0, 9) == 0 ? FUNC_RESERVED :
                      2'($urandom_range(1, 2))),
                     $urandom_range(0, 9) == 0 ? $urandom : ip_pool[$urandom_range(0, 5)]
                         + $urandom_range(0, 3),
                     $urandom_range(0, 3), 8'($urandom_range(0, 255)), clock_now);
        return c;
    endfunction

    task automatic test_directed();
        logic [31:0] t;
        t = 32'd100;
        send_route_cmd(make_cmd(FUNC_INSERT, 32'h0A00_0001, 32'd1, 8'd10, t));
        send_route_cmd(make_cmd(FUNC_INSERT, 32'h0A00_0001, 32'd1, 8'd12, t + 1));
        send_route_cmd(make_cmd(FUNC_INSERT, 32'h0A00_0001, 32'd1, 8'd10, t + 2));
        send_route_cmd(make_cmd(FUNC_INSERT, 32'h0A00_0001, 32'd1, 8'd5, t + 3));
        send_route_cmd(make_cmd(FUNC_INSERT, 32'h0A00_0001, 32'd2, 8'd7, t + 3));
        send_route_cmd(make_cmd(FUNC_SEARCH_IP, 32'h0A00_0001, 32'd9, 8'd0, t + 4));
        send_route_cmd(make_cmd(FUNC_SEARCH_EXACT, 32'h0A00_0001, 32'd2, 8'd0, t + 4));
        send_route_cmd(make_cmd(FUNC_SEARCH_EXACT, 32'h0A00_0001, 32'd3, 8'd0, t + 4));
        send_route_cmd(make_cmd(FUNC_RESERVED, 32'h0A00_0001, 32'd1, 8'd0, t + 4));
        send_route_cmd('1);
        send_route_cmd('0);
        send_route_cmd(make_cmd(FUNC_SEARCH_IP, 32'hFFFF_FFFF, 32'd0, 8'd0, 32'd0));
        // Aging: an insert at t + 65 drops every entry stamped more than 60 seconds earlier,
        // and a stamp ahead of the clock wraps to a large age.
        send_route_cmd(make_cmd(FUNC_INSERT, 32'h0A00_0002, 32'd1, 8'd3, t + 65));
        send_route_cmd(make_cmd(FUNC_SEARCH_IP, 32'h0A00_0001, 32'd0, 8'd0, t + 65));
        send_route_cmd(make_cmd(FUNC_INSERT, 32'h0A00_0003, 32'd1, 8'd3, 32'd10));
        // Fill the table with one clock value, then overflow it.
        for (int i = 0; i < TABLE_ENTRIES + 1; i++)
            send_route_cmd(make_cmd(FUNC_INSERT, 32'hC0A8_0000 + i, 32'd7, 8'd1, 32'd10));
        send_route_cmd(make_cmd(FUNC_SEARCH_EXACT, 32'hC0A8_0004, 32'd7, 8'd0, 32'd10));
        clock_now = 32'd10;
    endtask

    task automatic test_timeout_sweep();
        logic [31:0] settings [5] = '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'd1000, 32'd60};
        foreach (settings[k]) begin
            set_age_limit(settings[k]);
            repeat (RANDOM_PER_PHASE) send_route_cmd(random_cmd());
        end
    endtask

    task automatic test_output_backpressure();
        hold_req_count++;
        repeat (20) send_route_cmd(random_cmd());
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        offering = 1'b0;
        burst_left = 0;
        hold_req_count = 0;
        clock_now = 32'd0;
        age_limit = AGE_LIMIT_RST;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i] = '0;
            tbl_bcast[i] = '0;
            tbl_mac[i] = '0;
            tbl_iface[i] = '0;
            tbl_hops[i] = '0;
            tbl_stamp[i] = '0;
        end
        foreach (ip_pool[k])
            ip_pool[k] = $urandom;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_timeout_sweep();
        test_output_backpressure();
        drain_results();

        if (error_count == 0)
            $display("route_table_aging_core test passed");
        else
            $display("route_table_aging_core test failed");
        $finish;
    end

endmodule
